// ===== hw/rtl/pbu_pkg.sv =====
package pbu_pkg;

    // blend mode codes
    typedef enum logic [1:0] {
        MODE_OPAQUE = 2'd0,
        MODE_ALPHA  = 2'd1,
        MODE_ADD    = 2'd2
    } blend_mode_t;

    // configuration register indexes
    typedef enum logic [2:0] {
        REG_BLEND_MODE = 3'd0,
        REG_TINT_RED   = 3'd1,
        REG_TINT_GREEN = 3'd2,
        REG_TINT_BLUE  = 3'd3,
        REG_TINT_ALPHA = 3'd4,
        REG_BRIGHTNESS = 3'd5
    } cfg_index_t;

    localparam logic [7:0] TINT_RESET   = 8'd255;
    localparam logic [7:0] BRIGHT_RESET = 8'h10;
    localparam logic [7:0] BRIGHT_MAX   = 8'd128;
    localparam logic [7:0] CHAN_MAX     = 8'd255;
    localparam logic [8:0] UNITY        = 9'd256;

    typedef struct packed {
        logic [7:0] src_blue;
        logic [7:0] src_green;
        logic [7:0] src_red;
        logic [7:0] src_alpha;
        logic [7:0] dst_blue;
        logic [7:0] dst_green;
        logic [7:0] dst_red;
        logic [7:0] dst_alpha;
    } pixel_t;

    typedef struct packed {
        logic [7:0] out_blue;
        logic [7:0] out_green;
        logic [7:0] out_red;
        logic [7:0] out_alpha;
    } result_t;

    // load enables of the four pipeline stages
    typedef struct packed {
        logic s1;
        logic s2;
        logic s3;
        logic s4;
    } stage_en_t;

    // (t * 0x102) >> 8 equals t + t[7]
    function automatic logic [8:0] map_scale(input logic [7:0] t);
        map_scale = {1'b0, t} + {8'd0, t[7]};
    endfunction

endpackage

// ===== hw/rtl/pixel_blend_unit.sv =====
// pixel_blend_unit: ARGB8888 blender for a pixel stream into a framebuffer.
// pixel channel: one request carries a source and the current destination
// pixel; it is taken at a clock edge with pixel_valid high and pixel_stall low.
// result channel: one request per pixel, the new destination pixel, taken
// at an edge with result_valid high and result_stall low, in input order.
// cfg channel: cfg_index selects blend_mode, tint red/green/blue/alpha or
// brightness; cfg_ready is always high and unknown indexes are dropped.
// write registers only while no pixel is in flight.
// result_valid rises once the pixel has passed through the stage registers
// v1 to v4; throughput is one pixel per clock while the result is not
// stalled, set by a four stage pipeline (tint multiply, brightness
// multiply, blend products, blend sum and mode select).
// reset (rst_n low, asynchronous) empties the pipeline and loads the
// register defaults: opaque mode, all tints 255, brightness 16.
// when the receiver stalls, the result holds and earlier stages keep
// filling bubbles; pixel_stall rises only once every stage holds a pixel.
module pixel_blend_unit (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             pixel_valid,
    output logic             pixel_stall,
    input  pbu_pkg::pixel_t  pixel,
    output logic             result_valid,
    input  logic             result_stall,
    output pbu_pkg::result_t result,
    input  logic             cfg_valid,
    output logic             cfg_ready,
    input  logic [2:0]       cfg_index,
    input  logic [7:0]       cfg_data
);

    // configuration registers
    logic [1:0] blend_mode_reg;
    logic [7:0] tint_red_reg;
    logic [7:0] tint_green_reg;
    logic [7:0] tint_blue_reg;
    logic [7:0] tint_alpha_reg;
    logic [7:0] brightness_reg;

    // stage valid bits
    logic v1_reg;
    logic v2_reg;
    logic v3_reg;
    logic v4_reg;

    // per stage ready chain, back to front
    logic rdy1;
    logic rdy2;
    logic rdy3;
    logic rdy4;
    pbu_pkg::stage_en_t en;

    // alpha path
    logic [17:0] alpha_prod;
    logic [8:0]  a1_reg;
    logic [8:0]  a2_reg;
    logic [8:0]  a3_reg;
    logic [7:0]  sa1_reg;
    logic [7:0]  sa2_reg;
    logic [7:0]  sa3_reg;
    logic [7:0]  da1_reg;
    logic [7:0]  da2_reg;
    logic [7:0]  da3_reg;
    logic [7:0]  oa_next;
    logic [7:0]  oa4_reg;
    logic [7:0]  add_alpha;

    logic [7:0]  bright;
    logic [7:0]  out_blue;
    logic [7:0]  out_green;
    logic [7:0]  out_red;

    // config writes always accepted
    assign cfg_ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            blend_mode_reg <= pbu_pkg::MODE_OPAQUE;
            tint_red_reg   <= pbu_pkg::TINT_RESET;
            tint_green_reg <= pbu_pkg::TINT_RESET;
            tint_blue_reg  <= pbu_pkg::TINT_RESET;
            tint_alpha_reg <= pbu_pkg::TINT_RESET;
            brightness_reg <= pbu_pkg::BRIGHT_RESET;
        end
        else if (cfg_valid && cfg_ready)
        begin
            unique case (cfg_index)
                pbu_pkg::REG_BLEND_MODE: blend_mode_reg <= cfg_data[1:0];
                pbu_pkg::REG_TINT_RED:   tint_red_reg   <= cfg_data;
                pbu_pkg::REG_TINT_GREEN: tint_green_reg <= cfg_data;
                pbu_pkg::REG_TINT_BLUE:  tint_blue_reg  <= cfg_data;
                pbu_pkg::REG_TINT_ALPHA: tint_alpha_reg <= cfg_data;
                pbu_pkg::REG_BRIGHTNESS: brightness_reg <= cfg_data;
                default:                 ;
            endcase
        end
    end

    // brightness is used clamped, register keeps the raw value
    assign bright = (brightness_reg > pbu_pkg::BRIGHT_MAX) ? pbu_pkg::BRIGHT_MAX
                                                           : brightness_reg;

    // a stage loads when it is empty or its contents move on
    assign rdy4 = !v4_reg || !result_stall;
    assign rdy3 = !v3_reg || rdy4;
    assign rdy2 = !v2_reg || rdy3;
    assign rdy1 = !v1_reg || rdy2;

    assign en.s1 = rdy1;
    assign en.s2 = rdy2;
    assign en.s3 = rdy3;
    assign en.s4 = rdy4;

    assign pixel_stall = !rdy1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v1_reg <= 1'b0;
            v2_reg <= 1'b0;
            v3_reg <= 1'b0;
            v4_reg <= 1'b0;
        end
        else
        begin
            if (rdy1)
            begin
                v1_reg <= pixel_valid;
            end
            if (rdy2)
            begin
                v2_reg <= v1_reg;
            end
            if (rdy3)
            begin
                v3_reg <= v2_reg;
            end
            if (rdy4)
            begin
                v4_reg <= v3_reg;
            end
        end
    end

    // scaled alpha, 0..256
    assign alpha_prod = {9'd0, pbu_pkg::map_scale(pixel.src_alpha)}
                      * {9'd0, pbu_pkg::map_scale(tint_alpha_reg)};

    always_ff @(posedge clk)
    begin
        if (en.s1)
        begin
            a1_reg  <= alpha_prod[16:8];
            sa1_reg <= pixel.src_alpha;
            da1_reg <= pixel.dst_alpha;
        end
        if (en.s2)
        begin
            a2_reg  <= a1_reg;
            sa2_reg <= sa1_reg;
            da2_reg <= da1_reg;
        end
        if (en.s3)
        begin
            a3_reg  <= a2_reg;
            sa3_reg <= sa2_reg;
            da3_reg <= da2_reg;
        end
        if (en.s4)
        begin
            oa4_reg <= oa_next;
        end
    end

    // alpha bytes add modulo 256
    assign add_alpha = da3_reg + sa3_reg;

    always_comb
    begin
        unique case (blend_mode_reg)
            pbu_pkg::MODE_OPAQUE: oa_next = sa3_reg;
            // zero alpha leaves the destination untouched, full alpha wraps to 0
            pbu_pkg::MODE_ALPHA:  oa_next = (a3_reg == 9'd0) ? da3_reg : a3_reg[7:0];
            pbu_pkg::MODE_ADD:    oa_next = add_alpha;
            default:              oa_next = da3_reg;
        endcase
    end

    // color channels
    pbu_chan u_chan_blue (
        .clk           (clk),
        .en            (en),
        .src           (pixel.src_blue),
        .dst           (pixel.dst_blue),
        .tint_scale    (pbu_pkg::map_scale(tint_blue_reg)),
        .bright        (bright),
        .mode          (blend_mode_reg),
        .alpha_s2      (a2_reg),
        .alpha_zero_s3 (a3_reg == 9'd0),
        .result        (out_blue)
    );

    pbu_chan u_chan_green (
        .clk           (clk),
        .en            (en),
        .src           (pixel.src_green),
        .dst           (pixel.dst_green),
        .tint_scale    (pbu_pkg::map_scale(tint_green_reg)),
        .bright        (bright),
        .mode          (blend_mode_reg),
        .alpha_s2      (a2_reg),
        .alpha_zero_s3 (a3_reg == 9'd0),
        .result        (out_green)
    );

    pbu_chan u_chan_red (
        .clk           (clk),
        .en            (en),
        .src           (pixel.src_red),
        .dst           (pixel.dst_red),
        .tint_scale    (pbu_pkg::map_scale(tint_red_reg)),
        .bright        (bright),
        .mode          (blend_mode_reg),
        .alpha_s2      (a2_reg),
        .alpha_zero_s3 (a3_reg == 9'd0),
        .result        (out_red)
    );

    assign result_valid     = v4_reg;
    assign result.out_blue  = out_blue;
    assign result.out_green = out_green;
    assign result.out_red   = out_red;
    assign result.out_alpha = oa4_reg;

endmodule

// ===== hw/rtl/pbu_chan.sv =====
module pbu_chan (
    input  logic              clk,
    input  pbu_pkg::stage_en_t en,
    input  logic [7:0]        src,
    input  logic [7:0]        dst,
    input  logic [8:0]        tint_scale,
    input  logic [7:0]        bright,
    input  logic [1:0]        mode,
    input  logic [8:0]        alpha_s2,
    input  logic              alpha_zero_s3,
    output logic [7:0]        result
);

    logic [16:0] tint_prod;
    logic [15:0] bright_prod;
    logic [16:0] blend_sum;
    logic [8:0]  add_sum;
    logic [7:0]  out_next;

    logic [7:0]  v1_reg;
    logic [7:0]  d1_reg;
    logic [7:0]  sc2_reg;
    logic [7:0]  d2_reg;
    logic [16:0] pa3_reg;
    logic [16:0] pd3_reg;
    logic [7:0]  sc3_reg;
    logic [7:0]  d3_reg;
    logic [7:0]  out4_reg;

    assign tint_prod   = {9'd0, src} * {8'd0, tint_scale};
    assign bright_prod = {8'd0, v1_reg} * {8'd0, bright};

    // stage 1: tint, stage 2: brightness
    always_ff @(posedge clk)
    begin
        if (en.s1)
        begin
            v1_reg <= tint_prod[15:8];
            d1_reg <= dst;
        end
        if (en.s2)
        begin
            sc2_reg <= bright_prod[15:8];
            d2_reg  <= d1_reg;
        end
        if (en.s3)
        begin
            pa3_reg <= {9'd0, sc2_reg} * {8'd0, alpha_s2};
            pd3_reg <= {9'd0, d2_reg} * {8'd0, pbu_pkg::UNITY - alpha_s2};
            sc3_reg <= sc2_reg;
            d3_reg  <= d2_reg;
        end
        if (en.s4)
        begin
            out4_reg <= out_next;
        end
    end

    assign blend_sum = pa3_reg + pd3_reg;
    assign add_sum   = {1'b0, d3_reg} + {1'b0, sc3_reg};

    always_comb
    begin
        unique case (mode)
            pbu_pkg::MODE_OPAQUE: out_next = sc3_reg;
            pbu_pkg::MODE_ALPHA:  out_next = alpha_zero_s3 ? d3_reg : blend_sum[15:8];
            pbu_pkg::MODE_ADD:    out_next = add_sum[8] ? pbu_pkg::CHAN_MAX : add_sum[7:0];
            default:              out_next = d3_reg;
        endcase
    end

    assign result = out4_reg;

endmodule
